### src/crg_pkg.sv
// ----------------------------------------------------------------------------
// crg_pkg
// shared widths, register indexes and pipeline side-band type for the
// camera ray generator
// ----------------------------------------------------------------------------
package crg_pkg;

    // fixed point format of config lanes and results
    localparam int FRAC_BITS = 12;
    localparam int IN_FRAC   = 16;
    localparam int LANE_W    = 21;
    localparam int OUT_W     = 24;
    localparam int COORD_W   = 17;
    localparam int SCALE_W   = 20;
    localparam int CFG_W     = 63;
    localparam int CFG_IDX_W = 3;

    // offset datapath
    localparam int DU_W   = COORD_W + 1;
    localparam int PROD_W = DU_W + LANE_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int T_W    = SUM_W + SCALE_W + 1;
    localparam int SH     = IN_FRAC + FRAC_BITS;
    localparam int OFF_W  = T_W + 1 - SH;

    // range reduction
    localparam int W_RAW    = OFF_W + 1;
    localparam int W_W      = (W_RAW > 31) ? W_RAW : 31;
    localparam int KMAX     = W_W - 30;
    localparam int KSEL_W   = $clog2(KMAX + 1);
    localparam int NV_W     = 31;
    localparam int MAG_W    = 30;
    localparam int SHIFT_W  = $clog2(MAG_W);

    // square root and divide
    localparam int SQ1_W  = 60;
    localparam int SQ_W   = 62;
    localparam int TR_W   = SQ_W + 2;
    localparam int ROOT_W = 31;
    localparam int Q_W    = FRAC_BITS + 2;
    localparam int DVD_W  = MAG_W + FRAC_BITS + 1;
    localparam int DS_W   = ROOT_W + Q_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 3'd5;

    // projection modes
    localparam logic MODE_ORTHO = 1'b0;
    localparam logic MODE_PERSP = 1'b1;

    typedef logic signed [LANE_W-1:0] t_lane;

    // control that travels with each item
    typedef struct packed {
        logic                      valid;
        logic                      zero;
        logic [2:0]                neg;
        logic [2:0][OUT_W-1:0]     org;
    } t_side;

endpackage

### src/crg_offset.sv
// ----------------------------------------------------------------------------
// crg_offset
// screen offset (dv*up + du*side)*scale, orthographic origin and the
// unnormalized perspective direction, five register stages
// ----------------------------------------------------------------------------
module crg_offset (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [crg_pkg::COORD_W-1:0]   i_u_coord,
    input  logic [crg_pkg::COORD_W-1:0]   i_v_coord,
    input  logic                          i_mode,
    input  crg_pkg::t_lane                i_center [3],
    input  crg_pkg::t_lane                i_view [3],
    input  crg_pkg::t_lane                i_up [3],
    input  crg_pkg::t_lane                i_side [3],
    input  logic [crg_pkg::SCALE_W-1:0]   i_scale,
    output crg_pkg::t_side                o_side,
    output logic signed [crg_pkg::W_W-1:0] o_w [3]
);
    import crg_pkg::*;

    localparam logic [DU_W-1:0]  HALF    = DU_W'(1 << (IN_FRAC - 1));
    localparam logic [T_W:0]     RND_ADD = (T_W + 1)'(1) << (SH - 1);
    localparam logic signed [OFF_W:0] SAT_HI = (OFF_W + 1)'(2 ** (OUT_W - 1) - 1);
    localparam logic signed [OFF_W:0] SAT_LO = (OFF_W + 1)'(-(2 ** (OUT_W - 1)));

    logic                     r1_valid, r2_valid, r3_valid, r4_valid;
    logic signed [DU_W-1:0]   r1_du, r1_dv;
    logic signed [PROD_W-1:0] r2_pu [3];
    logic signed [PROD_W-1:0] r2_ps [3];
    logic signed [SUM_W-1:0]  r3_s [3];
    logic signed [T_W-1:0]    r4_t [3];
    t_side                    r5_side, n5_side;
    logic signed [W_W-1:0]    r5_w [3];
    logic signed [W_W-1:0]    n5_w [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_du <= $signed({1'b0, i_u_coord} - HALF);
            r1_dv <= $signed({1'b0, i_v_coord} - HALF);
            for (int i = 0; i < 3; i++) begin
                r2_pu[i] <= PROD_W'(r1_dv * i_up[i]);
                r2_ps[i] <= PROD_W'(r1_du * i_side[i]);
                r3_s[i]  <= SUM_W'(r2_pu[i]) + SUM_W'(r2_ps[i]);
                r4_t[i]  <= T_W'(r3_s[i] * $signed({1'b0, i_scale}));
            end
        end
    end

    // round half up, then origin sum with saturation and direction sum
    always_comb begin
        logic signed [T_W:0]   t_r;
        logic signed [OFF_W-1:0] off;
        logic signed [OFF_W:0] cs;
        logic signed [OUT_W-1:0] org;
        n5_side       = '0;
        n5_side.valid = r4_valid;
        for (int i = 0; i < 3; i++) begin
            t_r = (T_W + 1)'(r4_t[i]) + $signed(RND_ADD);
            off = OFF_W'(t_r >>> SH);
            cs  = (OFF_W + 1)'(i_center[i]) + (OFF_W + 1)'(off);
            if (cs > SAT_HI) begin
                org = OUT_W'(SAT_HI);
            end else if (cs < SAT_LO) begin
                org = OUT_W'(SAT_LO);
            end else begin
                org = OUT_W'(cs);
            end
            if (i_mode == MODE_PERSP) begin
                org = OUT_W'(i_center[i]);
            end
            n5_side.org[i] = org;
            n5_w[i] = W_W'(i_view[i]) + W_W'(off);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_side <= '0;
        end else if (i_en) begin
            r5_side <= n5_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r5_w[i] <= n5_w[i];
            end
        end
    end

    assign o_side = r5_side;
    assign o_w    = r5_w;

endmodule

### src/crg_norm.sv
// ----------------------------------------------------------------------------
// crg_norm
// power of two range reduction: brings the largest component magnitude
// into [2^29, 2^30), four register stages
// ----------------------------------------------------------------------------
module crg_norm (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  crg_pkg::t_side                  i_side,
    input  logic signed [crg_pkg::W_W-1:0]  i_w [3],
    output crg_pkg::t_side                  o_side,
    output logic signed [crg_pkg::NV_W-1:0] o_v [3]
);
    import crg_pkg::*;

    localparam logic signed [W_W-1:0] LIM_P = W_W'(2 ** 30 - 1);
    localparam logic signed [W_W-1:0] LIM_N = W_W'(-(2 ** 30 - 1));

    t_side                   r1_side, r2_side, n2_side, r3_side, r4_side, n4_side;
    logic signed [NV_W-1:0]  r1_v [3];
    logic signed [NV_W-1:0]  n1_v [3];
    logic                    r1_down, n1_down;
    logic signed [NV_W-1:0]  r2_v [3];
    logic [MAG_W-1:0]        r2_m, n2_m;
    logic                    r2_down;
    logic signed [NV_W-1:0]  r3_v [3];
    logic [SHIFT_W-1:0]      r3_s, n3_s;
    logic signed [NV_W-1:0]  r4_v [3];

    // smallest floor shift that puts every component below 2^30
    always_comb begin
        logic [KMAX:0]         ok;
        logic signed [W_W-1:0] a;
        logic [KSEL_W-1:0]     ksel;
        for (int k = 0; k <= KMAX; k++) begin
            ok[k] = 1'b1;
            for (int i = 0; i < 3; i++) begin
                a = i_w[i] >>> k;
                if ((a > LIM_P) || (a < LIM_N)) begin
                    ok[k] = 1'b0;
                end
            end
        end
        ksel = '0;
        for (int k = KMAX; k >= 0; k--) begin
            if (ok[k]) begin
                ksel = KSEL_W'(k);
            end
        end
        n1_down = (ksel != '0);
        for (int i = 0; i < 3; i++) begin
            n1_v[i] = NV_W'(i_w[i] >>> ksel);
        end
    end

    // largest magnitude
    always_comb begin
        logic [MAG_W-1:0] mg;
        n2_m = '0;
        for (int i = 0; i < 3; i++) begin
            mg = MAG_W'(r1_v[i][NV_W-1] ? -r1_v[i] : r1_v[i]);
            if (mg > n2_m) begin
                n2_m = mg;
            end
        end
        n2_side      = r1_side;
        n2_side.zero = (n2_m == '0);
    end

    // left shift that brings a small maximum up to 2^29
    always_comb begin
        logic [SHIFT_W-1:0] msb;
        msb = SHIFT_W'(MAG_W - 1);
        if (!r2_down && (r2_m != '0)) begin
            for (int j = 0; j < MAG_W; j++) begin
                if (r2_m[j]) begin
                    msb = SHIFT_W'(j);
                end
            end
        end
        n3_s = SHIFT_W'(MAG_W - 1) - msb;
    end

    always_comb begin
        n4_side = r3_side;
        for (int i = 0; i < 3; i++) begin
            n4_side.neg[i] = r3_v[i][NV_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_side <= '0;
            r2_side <= '0;
            r3_side <= '0;
            r4_side <= '0;
        end else if (i_en) begin
            r1_side <= i_side;
            r2_side <= n2_side;
            r3_side <= r2_side;
            r4_side <= n4_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_down <= n1_down;
            r2_down <= r1_down;
            r2_m    <= n2_m;
            r3_s    <= n3_s;
            for (int i = 0; i < 3; i++) begin
                r1_v[i] <= n1_v[i];
                r2_v[i] <= r1_v[i];
                r3_v[i] <= r2_v[i];
                r4_v[i] <= r3_v[i] <<< r3_s;
            end
        end
    end

    assign o_side = r4_side;
    assign o_v    = r4_v;

endmodule

### src/crg_isqrt.sv
// ----------------------------------------------------------------------------
// crg_isqrt
// sum of squares and a pipelined integer square root, one result bit
// per stage
// ----------------------------------------------------------------------------
module crg_isqrt (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  crg_pkg::t_side                     i_side,
    input  logic signed [crg_pkg::NV_W-1:0]    i_v [3],
    output crg_pkg::t_side                     o_side,
    output logic [2:0][crg_pkg::MAG_W-1:0]     o_mag,
    output logic [crg_pkg::ROOT_W-1:0]         o_len
);
    import crg_pkg::*;

    t_side                  r_sq_side;
    logic [SQ1_W-1:0]       r_sq [3];
    logic [2:0][MAG_W-1:0]  r_sq_mag;

    logic [SQ_W-1:0]        r_rem  [ROOT_W];
    logic [ROOT_W-1:0]      r_root [ROOT_W+1];
    logic [2:0][MAG_W-1:0]  r_mag  [ROOT_W+1];
    t_side                  r_sd   [ROOT_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_side <= '0;
            r_sd[0]   <= '0;
        end else if (i_en) begin
            r_sq_side <= i_side;
            r_sd[0]   <= r_sq_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_sq[i]     <= SQ1_W'(i_v[i] * i_v[i]);
                r_sq_mag[i] <= MAG_W'(i_v[i][NV_W-1] ? -i_v[i] : i_v[i]);
            end
            r_rem[0]  <= SQ_W'(r_sq[0]) + SQ_W'(r_sq[1]) + SQ_W'(r_sq[2]);
            r_root[0] <= '0;
            r_mag[0]  <= r_sq_mag;
        end
    end

    for (genvar s = 1; s <= ROOT_W; s++) begin : g_stage
        localparam int B = ROOT_W - s;
        logic [TR_W-1:0]   trial;
        logic              take;
        assign trial = (TR_W'(r_root[s-1]) << (B + 1)) + (TR_W'(1) << (2 * B));
        assign take  = (TR_W'(r_rem[s-1]) >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sd[s] <= '0;
            end else if (i_en) begin
                r_sd[s] <= r_sd[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_mag[s]  <= r_mag[s-1];
                r_root[s] <= take ? (r_root[s-1] | (ROOT_W'(1) << B)) : r_root[s-1];
            end
        end

        if (s < ROOT_W) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= take ? (r_rem[s-1] - SQ_W'(trial)) : r_rem[s-1];
                end
            end
        end
    end

    assign o_side = r_sd[ROOT_W];
    assign o_mag  = r_mag[ROOT_W];
    assign o_len  = r_root[ROOT_W];

endmodule

### src/crg_div.sv
// ----------------------------------------------------------------------------
// crg_div
// pipelined restoring divide of each magnitude by the length, rounded
// half away from zero, one quotient bit per stage
// ----------------------------------------------------------------------------
module crg_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  crg_pkg::t_side                 i_side,
    input  logic [2:0][crg_pkg::MAG_W-1:0] i_mag,
    input  logic [crg_pkg::ROOT_W-1:0]     i_len,
    output crg_pkg::t_side                 o_side,
    output logic [2:0][crg_pkg::Q_W-1:0]   o_q
);
    import crg_pkg::*;

    logic [2:0][DVD_W-1:0] r_rem [Q_W];
    logic [ROOT_W-1:0]     r_len [Q_W];
    logic [2:0][Q_W-1:0]   r_q   [Q_W+1];
    t_side                 r_sd  [Q_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sd[0] <= '0;
        end else if (i_en) begin
            r_sd[0] <= i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_rem[0][i] <= (DVD_W'(i_mag[i]) << FRAC_BITS) + DVD_W'(i_len >> 1);
            end
            r_len[0] <= i_len;
            r_q[0]   <= '0;
        end
    end

    for (genvar s = 1; s <= Q_W; s++) begin : g_stage
        localparam int B = Q_W - s;
        logic [DS_W-1:0] dsub;
        logic [2:0]      take;
        assign dsub = DS_W'(r_len[s-1]) << B;
        always_comb begin
            for (int i = 0; i < 3; i++) begin
                take[i] = (DS_W'(r_rem[s-1][i]) >= dsub);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sd[s] <= '0;
            end else if (i_en) begin
                r_sd[s] <= r_sd[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int i = 0; i < 3; i++) begin
                    r_q[s][i] <= take[i] ? (r_q[s-1][i] | (Q_W'(1) << B)) : r_q[s-1][i];
                end
            end
        end

        if (s < Q_W) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_len[s] <= r_len[s-1];
                    for (int i = 0; i < 3; i++) begin
                        r_rem[s][i] <= take[i] ? (r_rem[s-1][i] - DVD_W'(dsub))
                                               : r_rem[s-1][i];
                    end
                end
            end
        end
    end

    assign o_side = r_sd[Q_W];
    assign o_q    = r_q[Q_W];

endmodule

### src/camera_ray_generator.sv
// ----------------------------------------------------------------------------
// camera_ray_generator
// turns a normalized screen point (u, v) into a ray origin and direction
// for an orthographic or a perspective camera, Q12.12 fixed point
// ----------------------------------------------------------------------------
// throughput: one ray per cycle unless stalled, every stage is one register
// the whole pipeline holds while a result waits under stall
// the square root and the divide cost one stage per result bit
// reset (synchronous, active low) empties the pipeline and loads the
// register defaults: orthographic, zero vectors, scale of one
// ----------------------------------------------------------------------------
module camera_ray_generator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // config write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [crg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [crg_pkg::CFG_W-1:0]      i_cfg_data,
    // screen point channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [crg_pkg::COORD_W-1:0]    i_u_coord,
    input  logic [crg_pkg::COORD_W-1:0]    i_v_coord,
    // ray channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [crg_pkg::OUT_W-1:0] o_origin_x,
    output logic signed [crg_pkg::OUT_W-1:0] o_origin_y,
    output logic signed [crg_pkg::OUT_W-1:0] o_origin_z,
    output logic signed [crg_pkg::OUT_W-1:0] o_dir_x,
    output logic signed [crg_pkg::OUT_W-1:0] o_dir_y,
    output logic signed [crg_pkg::OUT_W-1:0] o_dir_z
);
    import crg_pkg::*;

    // configuration registers
    logic               r_mode;
    logic [CFG_W-1:0]   r_center;
    logic [CFG_W-1:0]   r_view;
    logic [CFG_W-1:0]   r_up;
    logic [CFG_W-1:0]   r_side;
    logic [SCALE_W-1:0] r_scale;

    // unpacked x, y, z lanes
    t_lane              center [3];
    t_lane              view [3];
    t_lane              up [3];
    t_lane              side [3];

    // global advance: the pipeline moves unless a result is held by stall
    logic               en;

    t_side              off_side, norm_side, sq_side, div_side;
    logic signed [W_W-1:0]  off_w [3];
    logic signed [NV_W-1:0] norm_v [3];
    logic [2:0][MAG_W-1:0]  sq_mag;
    logic [ROOT_W-1:0]      sq_len;
    logic [2:0][Q_W-1:0]    div_q;

    // output register
    logic                    r_out_valid;
    logic signed [OUT_W-1:0] r_org [3];
    logic signed [OUT_W-1:0] r_dir [3];
    logic signed [OUT_W-1:0] n_dir [3];

    assign o_cfg_ready = 1'b1;

    // config transfer, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_ORTHO;
            r_center <= '0;
            r_view   <= '0;
            r_up     <= '0;
            r_side   <= '0;
            r_scale  <= SCALE_W'(1 << FRAC_BITS);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_MODE:   r_mode   <= i_cfg_data[0];
                CFG_CENTER: r_center <= i_cfg_data;
                CFG_VIEW:   r_view   <= i_cfg_data;
                CFG_UP:     r_up     <= i_cfg_data;
                CFG_SIDE:   r_side   <= i_cfg_data;
                CFG_SCALE:  r_scale  <= i_cfg_data[SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // x in bits 0..20, y in 21..41, z in 42..62
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            center[i] = r_center[LANE_W*i +: LANE_W];
            view[i]   = r_view[LANE_W*i +: LANE_W];
            up[i]     = r_up[LANE_W*i +: LANE_W];
            side[i]   = r_side[LANE_W*i +: LANE_W];
        end
    end

    assign en         = !r_out_valid || !i_out_stall;
    assign o_in_stall = !en;

    // offset, orthographic origin, raw direction
    crg_offset u_offset (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (i_in_valid),
        .i_u_coord (i_u_coord),
        .i_v_coord (i_v_coord),
        .i_mode    (r_mode),
        .i_center  (center),
        .i_view    (view),
        .i_up      (up),
        .i_side    (side),
        .i_scale   (r_scale),
        .o_side    (off_side),
        .o_w       (off_w)
    );

    // power of two range reduction
    crg_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_side  (off_side),
        .i_w     (off_w),
        .o_side  (norm_side),
        .o_v     (norm_v)
    );

    // length of the reduced vector
    crg_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_side  (norm_side),
        .i_v     (norm_v),
        .o_side  (sq_side),
        .o_mag   (sq_mag),
        .o_len   (sq_len)
    );

    // component over length
    crg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_side  (sq_side),
        .i_mag   (sq_mag),
        .i_len   (sq_len),
        .o_side  (div_side),
        .o_q     (div_q)
    );

    // orthographic keeps the view direction, perspective takes the
    // signed quotient, and a zero sum vector gives a zero direction
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_mode == MODE_ORTHO) begin
                n_dir[i] = OUT_W'(view[i]);
            end else if (div_side.zero) begin
                n_dir[i] = '0;
            end else if (div_side.neg[i]) begin
                n_dir[i] = -$signed(OUT_W'(div_q[i]));
            end else begin
                n_dir[i] = $signed(OUT_W'(div_q[i]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= div_side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_org[i] <= $signed(div_side.org[i]);
                r_dir[i] <= n_dir[i];
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_origin_x  = r_org[0];
    assign o_origin_y  = r_org[1];
    assign o_origin_z  = r_org[2];
    assign o_dir_x     = r_dir[0];
    assign o_dir_y     = r_dir[1];
    assign o_dir_z     = r_dir[2];

endmodule

### src/crg_checker.sv
// ----------------------------------------------------------------------------
// crg_checker
// port level checks of the camera ray generator, bound to the top level
// ----------------------------------------------------------------------------
module crg_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic signed [crg_pkg::OUT_W-1:0] o_origin_x,
    input logic signed [crg_pkg::OUT_W-1:0] o_dir_x
);

    // a held result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped under stall");

    // a held result keeps its x origin and x direction
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_origin_x) && $stable(o_dir_x))
        else $error("result changed under stall");

    // input is held back only while a result waits
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall == (o_out_valid && i_out_stall))
        else $error("input stall without a held result");

    // reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result offered right after reset");

endmodule

bind camera_ray_generator crg_checker u_crg_checker (.*);

### tb/crg_ray_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crg_ray_checker
// watches the config, screen point and ray channels, computes the expected
// ray for each accepted point and compares it with the whole received ray
// ----------------------------------------------------------------------------
module crg_ray_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [crg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [crg_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [crg_pkg::COORD_W-1:0]   i_u_coord,
    input  logic [crg_pkg::COORD_W-1:0]   i_v_coord,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [crg_pkg::OUT_W-1:0]     i_origin_x,
    input  logic [crg_pkg::OUT_W-1:0]     i_origin_y,
    input  logic [crg_pkg::OUT_W-1:0]     i_origin_z,
    input  logic [crg_pkg::OUT_W-1:0]     i_dir_x,
    input  logic [crg_pkg::OUT_W-1:0]     i_dir_y,
    input  logic [crg_pkg::OUT_W-1:0]     i_dir_z,
    output int                            o_fail_count,
    output int                            o_pending
);
    import crg_pkg::*;

    typedef logic [6*OUT_W-1:0] t_ray;

    logic               cam_mode;
    logic [CFG_W-1:0]   center_reg, view_reg, up_reg, side_reg;
    logic [SCALE_W-1:0] scale_reg;
    t_ray               expected_rays[$];

    function automatic longint lane_of(logic [CFG_W-1:0] p, int i);
        logic signed [LANE_W-1:0] f;
        f = p[LANE_W*i +: LANE_W];
        return longint'(f);
    endfunction

    function automatic longint floor_div2(longint x, int s);
        return x >>> s;
    endfunction

    function automatic longint clamp24(longint x);
        if (x > 64'sd8388607) return 64'sd8388607;
        if (x < -64'sd8388608) return -64'sd8388608;
        return x;
    endfunction

    function automatic longint abs64(longint x);
        return x < 0 ? -x : x;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic t_ray predict_ray(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
        longint du, dv, t, off, m;
        longint org[3], dir[3], w[3];
        longint unsigned sum, len, a, q;
        t_ray r;
        du = longint'(u) - 32768;
        dv = longint'(v) - 32768;
        for (int i = 0; i < 3; i++) begin
            t = (dv * lane_of(up_reg, i) + du * lane_of(side_reg, i)) * longint'(scale_reg);
            off = floor_div2(t + (64'sd1 <<< (IN_FRAC + FRAC_BITS - 1)), IN_FRAC + FRAC_BITS);
            if (cam_mode == MODE_ORTHO) begin
                org[i] = clamp24(lane_of(center_reg, i) + off);
                dir[i] = lane_of(view_reg, i);
            end else begin
                org[i] = lane_of(center_reg, i);
                w[i] = lane_of(view_reg, i) + off;
            end
        end
        if (cam_mode == MODE_PERSP) begin
            m = abs64(w[0]);
            if (abs64(w[1]) > m) m = abs64(w[1]);
            if (abs64(w[2]) > m) m = abs64(w[2]);
            if (m == 0) begin
                dir[0] = 0; dir[1] = 0; dir[2] = 0;
            end else begin
                while (m >= (64'sd1 <<< 30)) begin
                    for (int i = 0; i < 3; i++) w[i] = floor_div2(w[i], 1);
                    m = abs64(w[0]);
                    if (abs64(w[1]) > m) m = abs64(w[1]);
                    if (abs64(w[2]) > m) m = abs64(w[2]);
                end
                while (m < (64'sd1 <<< 29)) begin
                    for (int i = 0; i < 3; i++) w[i] = w[i] * 2;
                    m = m * 2;
                end
                sum = 0;
                for (int i = 0; i < 3; i++) sum = sum + longint'(w[i] * w[i]);
                len = int_sqrt(sum);
                for (int i = 0; i < 3; i++) begin
                    a = longint'(abs64(w[i])) << FRAC_BITS;
                    q = (a + len / 2) / len;
                    dir[i] = w[i] < 0 ? -longint'(q) : longint'(q);
                end
            end
        end
        for (int i = 0; i < 3; i++) begin
            r[OUT_W*i +: OUT_W] = org[i][OUT_W-1:0];
            r[OUT_W*(3+i) +: OUT_W] = OUT_W'(clamp24(dir[i]));
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_ray got, want;
        if (!i_rst_n) begin
            cam_mode <= MODE_ORTHO;
            center_reg <= '0;
            view_reg <= '0;
            up_reg <= '0;
            side_reg <= '0;
            scale_reg <= SCALE_W'(1 << FRAC_BITS);
            expected_rays.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MODE: begin
                        cam_mode <= i_cfg_data[0];
                    end
                    CFG_CENTER: begin
                        center_reg <= i_cfg_data;
                    end
                    CFG_VIEW: begin
                        view_reg <= i_cfg_data;
                    end
                    CFG_UP: begin
                        up_reg <= i_cfg_data;
                    end
                    CFG_SIDE: begin
                        side_reg <= i_cfg_data;
                    end
                    CFG_SCALE: begin
                        scale_reg <= i_cfg_data[SCALE_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            // config only moves while idle, so current values hold here
            if (i_in_valid && !i_in_stall)
                expected_rays.push_back(predict_ray(i_u_coord, i_v_coord));
            if (i_out_valid && !i_out_stall) begin
                got = {i_dir_z, i_dir_y, i_dir_x, i_origin_z, i_origin_y, i_origin_x};
                if (expected_rays.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected ray transfer: %h", got);
                end else begin
                    want = expected_rays.pop_front();
                    if (got !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("ray mismatch: expected %h got %h", want, got);
                    end
                end
            end
        end
        o_pending = expected_rays.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

endmodule

### tb/tb_camera_ray_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_camera_ray_generator
// random and directed screen points over several camera setups, with bursty
// input, random output stall and a separate checker predicting every ray
// ----------------------------------------------------------------------------
module tb_camera_ray_generator;
    import crg_pkg::*;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [COORD_W-1:0]   i_u_coord;
    logic [COORD_W-1:0]   i_v_coord;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic signed [OUT_W-1:0] o_origin_x, o_origin_y, o_origin_z;
    logic signed [OUT_W-1:0] o_dir_x, o_dir_y, o_dir_z;
    int                   fail_count;
    int                   rays_pending;
    int                   stall_mode;

    camera_ray_generator dut (.*);

    crg_ray_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall),
        .i_u_coord(i_u_coord), .i_v_coord(i_v_coord),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .i_origin_x(o_origin_x), .i_origin_y(o_origin_y), .i_origin_z(o_origin_z),
        .i_dir_x(o_dir_x), .i_dir_y(o_dir_y), .i_dir_z(o_dir_z),
        .o_fail_count(fail_count), .o_pending(rays_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // hard stop well past the slowest legal run
    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // receiver stall: mode switches between none, light, heavy, and long runs
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2: i_out_stall <= ($urandom_range(0, 3) != 0);
                default: i_out_stall <= ($urandom_range(0, 15) == 0) ? ~i_out_stall : i_out_stall;
            endcase
        end
    end

    // one register transfer, only while the pipeline is empty
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // holds valid until the point transfers, then maybe gaps
    task automatic send_point(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v, bit gap);
        i_in_valid <= 1'b1;
        i_u_coord <= u;
        i_v_coord <= v;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        if (gap) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
    endtask

    task automatic drain_pipe();
        i_in_valid <= 1'b0;
        while (rays_pending != 0) @(negedge i_clk);
        repeat (70) @(negedge i_clk);
    endtask

    function automatic logic [CFG_W-1:0] pack_vec(int x, int y, int z);
        return {LANE_W'(z), LANE_W'(y), LANE_W'(x)};
    endfunction

    function automatic logic [COORD_W-1:0] rand_coord();
        // mostly the legal screen range, sometimes beyond one
        if ($urandom_range(0, 9) == 0) return COORD_W'($urandom);
        return COORD_W'($urandom_range(0, 65536));
    endfunction

    task automatic random_camera(int sel);
        logic [CFG_W-1:0] r;
        write_reg(CFG_MODE, CFG_W'(sel[0]));
        case (sel % 3)
            0: begin
                // realistic unit basis
                write_reg(CFG_CENTER, pack_vec($urandom_range(0, 8000) - 4000, 1000, -3000));
                write_reg(CFG_VIEW, pack_vec(0, 0, -4096));
                write_reg(CFG_UP, pack_vec(0, 4096, 0));
                write_reg(CFG_SIDE, pack_vec(4096, 0, 0));
                write_reg(CFG_SCALE, CFG_W'($urandom_range(1000, 12000)));
            end
            1: begin
                // extreme lanes and scale for saturation
                write_reg(CFG_CENTER, pack_vec(1048575, -1048576, 1048575));
                write_reg(CFG_VIEW, pack_vec(-1048576, 1048575, 0));
                write_reg(CFG_UP, pack_vec(-1048576, 1048575, -1048576));
                write_reg(CFG_SIDE, pack_vec(1048575, -1048576, 1048575));
                write_reg(CFG_SCALE, CFG_W'(20'hFFFFF));
            end
            default: begin
                r = CFG_W'({$urandom, $urandom});
                write_reg(CFG_CENTER, r);
                r = CFG_W'({$urandom, $urandom});
                write_reg(CFG_VIEW, r);
                r = CFG_W'({$urandom, $urandom});
                write_reg(CFG_UP, r);
                r = CFG_W'({$urandom, $urandom});
                write_reg(CFG_SIDE, r);
                write_reg(CFG_SCALE, CFG_W'($urandom));
                // an unused index is ignored
                write_reg(CFG_UNUSED, CFG_W'({$urandom, $urandom}));
            end
        endcase
    endtask

    initial begin
        int burst;
        int gap_len;
        stall_mode = 0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_u_coord = '0;
        i_v_coord = '0;
        i_out_stall = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset defaults: zero vectors
        send_point(17'd0, 17'd0, 1'b0);
        send_point(17'd65536, 17'd65536, 1'b0);
        drain_pipe();

        // directed ortho corners, center and out-of-range coordinates
        random_camera(0);
        send_point(17'd0, 17'd0, 1'b0);
        send_point(17'd65536, 17'd0, 1'b1);
        send_point(17'd0, 17'd65536, 1'b0);
        send_point(17'd32768, 17'd32768, 1'b0);
        send_point(17'h1FFFF, 17'h1FFFF, 1'b0);
        drain_pipe();

        // perspective, zero direction sum, then saturation extremes
        write_reg(CFG_MODE, CFG_W'(MODE_PERSP));
        write_reg(CFG_VIEW, '0);
        send_point(17'd32768, 17'd32768, 1'b0);
        send_point(17'd0, 17'd65536, 1'b0);
        drain_pipe();
        random_camera(1);
        send_point(17'd0, 17'd0, 1'b0);
        send_point(17'h1FFFF, 17'd0, 1'b0);
        send_point(17'd0, 17'h1FFFF, 1'b1);
        drain_pipe();
        random_camera(4);
        send_point(17'd0, 17'd0, 1'b0);
        send_point(17'h1FFFF, 17'h1FFFF, 1'b0);
        send_point(17'd65536, 17'd32768, 1'b0);
        drain_pipe();

        // random phases over changing camera setups
        for (int ph = 0; ph < 12; ph++) begin
            random_camera($urandom_range(0, 5));
            for (int n = 0; n < 64; ) begin
                burst = $urandom_range(1, 20);
                for (int b = 0; b < burst; b++, n++)
                    send_point(rand_coord(), rand_coord(), 1'b0);
                gap_len = $urandom_range(0, 8);
                if (gap_len != 0) begin
                    i_in_valid <= 1'b0;
                    repeat (gap_len) @(negedge i_clk);
                end
            end
            drain_pipe();
        end

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
